@@ rtl/core/mbar_pkg.sv @@
// Shared constants and types for the moisture burst average reporter.
package mbar_pkg;

    localparam int SAMPLES_PER_BURST = 10;

    localparam int SAMPLE_W    = 10;
    localparam int SUM_W       = 14;
    localparam int BURST_CNT_W = 4;
    localparam int PCT_W       = 7;
    localparam int QUIET_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    localparam int DIV_NUM_W = 17;
    localparam int DIV_DEN_W = 10;
    localparam int DIV_CNT_W = 5;

    localparam logic [SAMPLE_W-1:0] WET_LEVEL_RST        = 10'd41;
    localparam logic [SAMPLE_W-1:0] DRY_LEVEL_RST        = 10'd1016;
    localparam logic [QUIET_W-1:0]  MAX_QUIET_BURSTS_RST = 8'd10;

    localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0]   PCT_EMPTY = 7'd0;
    localparam logic [QUIET_W-1:0] QUIET_SAT = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_WET_LEVEL        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_LEVEL        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUIET_BURSTS = 2'd2;

    localparam logic CAUSE_CHANGED = 1'b0;
    localparam logic CAUSE_QUIET   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_AVG  = 4'b0010,
        ST_PCT  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

endpackage

@@ rtl/core/mbar_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module mbar_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [mbar_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [mbar_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                            o_done,
    output logic [mbar_pkg::DIV_NUM_W-1:0]  o_quot
);
    import mbar_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIV_NUM_W-1:0]  r_shift;
    logic [DIV_DEN_W-1:0]  r_rem;
    logic [DIV_DEN_W-1:0]  r_den;

    logic [DIV_DEN_W:0]    rem_sh;
    logic [DIV_DEN_W+1:0]  trial;
    logic                  q_bit;

    assign rem_sh = {r_rem, r_shift[DIV_NUM_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_den};
    assign q_bit  = ~trial[DIV_DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_num;
            r_den   <= i_den;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[DIV_NUM_W-2:0], q_bit};
            r_rem   <= q_bit ? trial[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_shift;

endmodule

@@ rtl/core/moisture_burst_average_reporter_core.sv @@
// Top level: burst accumulation, average and percentage mapping, report filter.
//
//  channel  | handshake                          | payload
//  ---------+------------------------------------+------------------------------------------
//  sample   | i_sample_valid / o_sample_ready    | i_sample
//  report   | o_report_valid / i_report_ready    | o_moisture_percent, o_average_raw,
//           |                                    | o_report_cause
//  config   | i_cfg_we (no wait)                 | i_cfg_index, i_cfg_data
//
// A sample that does not close a burst is only accumulated. A closing sample
// starts the division for the average and, when the average lies between
// the levels, a second one for the percentage: both divisions share one
// bit-serial divider, one quotient bit per cycle.
// Reset is synchronous and restores the register defaults.
// A pending report waits in the output register; the next burst end stalls
// only if that register is still full when it needs it.
module moisture_burst_average_reporter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_sample_valid,
    output logic                             o_sample_ready,
    input  logic [mbar_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                             o_report_valid,
    input  logic                             i_report_ready,
    output logic [mbar_pkg::PCT_W-1:0]       o_moisture_percent,
    output logic [mbar_pkg::SAMPLE_W-1:0]    o_average_raw,
    output logic                             o_report_cause,
    input  logic                             i_cfg_we,
    input  logic [mbar_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbar_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mbar_pkg::*;

    t_state                 r_state, n_state;
    logic [SAMPLE_W-1:0]    r_wet, r_dry;
    logic [QUIET_W-1:0]     r_max_quiet;
    logic [SUM_W-1:0]       r_sum;
    logic [BURST_CNT_W-1:0] r_count;
    logic [PCT_W-1:0]       r_last;
    logic [QUIET_W-1:0]     r_quiet;
    logic [SAMPLE_W-1:0]    r_avg;
    logic [PCT_W-1:0]       r_pct;
    logic                   r_out_valid;
    logic [PCT_W-1:0]       r_out_pct;
    logic [SAMPLE_W-1:0]    r_out_avg;
    logic                   r_out_cause;

    logic                   in_xfer;
    logic                   burst_end;
    logic [SUM_W-1:0]       n_sum;
    logic                   div_start;
    logic [DIV_NUM_W-1:0]   div_num;
    logic [DIV_DEN_W-1:0]   div_den;
    logic                   div_done;
    logic [DIV_NUM_W-1:0]   div_quot;

    logic [SAMPLE_W-1:0]    avg_q;
    logic [SAMPLE_W-1:0]    delta;
    logic [DIV_NUM_W-1:0]   delta_x100;
    logic [SAMPLE_W-1:0]    span;
    logic [PCT_W-1:0]       drop;

    logic [QUIET_W-1:0]     quiet_inc;
    logic                   changed;
    logic                   quiet_hit;
    logic                   out_free;
    logic                   load_out;

    assign o_sample_ready = (r_state == ST_IDLE);
    assign in_xfer        = i_sample_valid && o_sample_ready;
    assign n_sum          = r_sum + SUM_W'(i_sample);
    assign burst_end      = (r_count == BURST_CNT_W'(SAMPLES_PER_BURST - 1));

    assign avg_q      = div_quot[SAMPLE_W-1:0];
    assign delta      = avg_q - r_wet;
    assign delta_x100 = (DIV_NUM_W'(delta) << 6) + (DIV_NUM_W'(delta) << 5)
                      + (DIV_NUM_W'(delta) << 2);
    assign span       = r_dry - r_wet;
    assign drop       = (div_quot >= DIV_NUM_W'(PCT_FULL)) ? PCT_FULL
                                                           : div_quot[PCT_W-1:0];

    assign quiet_inc = (r_quiet == QUIET_SAT) ? r_quiet : r_quiet + 1'b1;
    assign changed   = (r_pct != r_last);
    assign quiet_hit = (quiet_inc > r_max_quiet);
    assign out_free  = !r_out_valid || i_report_ready;
    assign load_out  = (r_state == ST_FIN) && (changed || quiet_hit) && out_free;

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num   = DIV_NUM_W'(n_sum);
        div_den   = DIV_DEN_W'(SAMPLES_PER_BURST);
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && burst_end) begin
                    div_start = 1'b1;
                    n_state   = ST_AVG;
                end
            end
            ST_AVG: begin
                if (div_done) begin
                    if (r_dry > r_wet && avg_q > r_wet && avg_q < r_dry) begin
                        div_start = 1'b1;
                        div_num   = delta_x100;
                        div_den   = span;
                        n_state   = ST_PCT;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_PCT: begin
                if (div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!(changed || quiet_hit) || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    mbar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wet       <= WET_LEVEL_RST;
            r_dry       <= DRY_LEVEL_RST;
            r_max_quiet <= MAX_QUIET_BURSTS_RST;
            r_sum       <= '0;
            r_count     <= '0;
            r_last      <= '0;
            r_quiet     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WET_LEVEL:        r_wet       <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_DRY_LEVEL:        r_dry       <= i_cfg_data[SAMPLE_W-1:0];
                    CFG_MAX_QUIET_BURSTS: r_max_quiet <= i_cfg_data[QUIET_W-1:0];
                    default: ;
                endcase
            end

            if (in_xfer) begin
                if (burst_end) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= r_count + 1'b1;
                end
            end

            if (r_state == ST_FIN) begin
                if (!(changed || quiet_hit)) begin
                    r_quiet <= quiet_inc;
                end else if (out_free) begin
                    r_quiet <= '0;
                    r_last  <= r_pct;
                end
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_report_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_AVG && div_done) begin
            r_avg <= avg_q;
            if (r_dry <= r_wet) begin
                r_pct <= (avg_q <= r_wet) ? PCT_FULL : PCT_EMPTY;
            end else if (avg_q <= r_wet) begin
                r_pct <= PCT_FULL;
            end else if (avg_q >= r_dry) begin
                r_pct <= PCT_EMPTY;
            end
        end
        if (r_state == ST_PCT && div_done) begin
            r_pct <= PCT_FULL - drop;
        end
        if (load_out) begin
            r_out_pct   <= r_pct;
            r_out_avg   <= r_avg;
            r_out_cause <= changed ? CAUSE_CHANGED : CAUSE_QUIET;
        end
    end

    assign o_report_valid     = r_out_valid;
    assign o_moisture_percent = r_out_pct;
    assign o_average_raw      = r_out_avg;
    assign o_report_cause     = r_out_cause;

endmodule

@@ tb/sv/mbar_report_checker.sv @@
// Checker: predicts moisture reports from accepted samples and register writes, compares them.
module mbar_report_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_sample_valid,
    input  logic                             i_sample_ready,
    input  logic [mbar_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                             i_report_valid,
    input  logic                             i_report_ready,
    input  logic [mbar_pkg::PCT_W-1:0]       i_moisture_percent,
    input  logic [mbar_pkg::SAMPLE_W-1:0]    i_average_raw,
    input  logic                             i_report_cause,
    input  logic                             i_cfg_we,
    input  logic [mbar_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbar_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_report_count
);
    import mbar_pkg::*;

    typedef struct packed {
        logic [PCT_W-1:0]    pct;
        logic [SAMPLE_W-1:0] avg;
        logic                cause;
    } t_report;

    t_report expected_reports[$];

    logic [SAMPLE_W-1:0]    wet_level;
    logic [SAMPLE_W-1:0]    dry_level;
    logic [QUIET_W-1:0]     max_quiet;
    logic [SUM_W-1:0]       burst_sum;
    logic [BURST_CNT_W-1:0] burst_count;
    logic [PCT_W-1:0]       last_reported;
    logic [QUIET_W-1:0]     quiet_count;

    int fail_count    = 0;
    int report_count  = 0;
    int pending_count = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending_count;
    assign o_report_count = report_count;

    function automatic logic [PCT_W-1:0] moisture_of(
        input logic [SAMPLE_W-1:0] avg,
        input logic [SAMPLE_W-1:0] wet,
        input logic [SAMPLE_W-1:0] dry
    );
        int drop;
        if (dry <= wet)
            return (avg <= wet) ? PCT_FULL : PCT_EMPTY;
        if (avg <= wet)
            return PCT_FULL;
        if (avg >= dry)
            return PCT_EMPTY;
        drop = ((int'(avg) - int'(wet)) * 100) / (int'(dry) - int'(wet));
        return (drop >= 100) ? PCT_EMPTY : PCT_W'(100 - drop);
    endfunction

    always @(posedge i_clk) begin : predict
        logic [SAMPLE_W-1:0] avg;
        logic [PCT_W-1:0]    pct;
        logic                changed;
        logic                quiet;
        t_report             got;
        t_report             want;
        if (!i_rst_n) begin
            wet_level     = WET_LEVEL_RST;
            dry_level     = DRY_LEVEL_RST;
            max_quiet     = MAX_QUIET_BURSTS_RST;
            burst_sum     = '0;
            burst_count   = '0;
            last_reported = '0;
            quiet_count   = '0;
            expected_reports.delete();
            pending_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WET_LEVEL:        wet_level = i_cfg_data;
                    CFG_DRY_LEVEL:        dry_level = i_cfg_data;
                    CFG_MAX_QUIET_BURSTS: max_quiet = i_cfg_data[QUIET_W-1:0];
                    default: ;
                endcase
            end
            if (i_sample_valid && i_sample_ready) begin
                burst_sum   = burst_sum + SUM_W'(i_sample);
                burst_count = burst_count + 1'b1;
                if (burst_count == BURST_CNT_W'(SAMPLES_PER_BURST)) begin
                    avg         = SAMPLE_W'(burst_sum / SAMPLES_PER_BURST);
                    burst_sum   = '0;
                    burst_count = '0;
                    pct         = moisture_of(avg, wet_level, dry_level);
                    if (quiet_count != QUIET_SAT)
                        quiet_count = quiet_count + 1'b1;
                    changed = (pct != last_reported);
                    quiet   = (quiet_count > max_quiet);
                    if (changed || quiet) begin
                        last_reported = pct;
                        quiet_count   = '0;
                        want.pct      = pct;
                        want.avg      = avg;
                        want.cause    = changed ? CAUSE_CHANGED : CAUSE_QUIET;
                        expected_reports.push_back(want);
                    end
                end
            end
            if (i_report_valid && i_report_ready) begin
                got.pct   = i_moisture_percent;
                got.avg   = i_average_raw;
                got.cause = i_report_cause;
                report_count++;
                if (expected_reports.size() == 0) begin
                    if (fail_count < 10)
                        $display("MISMATCH: unexpected report pct=%0d avg=%0d cause=%0d",
                                 got.pct, got.avg, got.cause);
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.pct !== want.pct || got.avg !== want.avg
                            || got.cause !== want.cause) begin
                        if (fail_count < 10) begin
                            $display("MISMATCH: report %0d expected pct=%0d avg=%0d cause=%0d",
                                     report_count, want.pct, want.avg, want.cause);
                            $display("          got pct=%0d avg=%0d cause=%0d",
                                     got.pct, got.avg, got.cause);
                        end
                        fail_count++;
                    end
                end
            end
            pending_count = expected_reports.size();
        end
    end

endmodule

@@ tb/sv/tb_moisture_burst_average_reporter_core.sv @@
// Testbench top: clock, reset, sample and register stimulus, report back-pressure, verdict.
module tb_moisture_burst_average_reporter_core;
    import mbar_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_SAMPLES = 1500;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_sample_valid = 1'b0;
    logic [SAMPLE_W-1:0]   i_sample       = '0;
    logic                  i_report_ready = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_sample_ready;
    logic                  o_report_valid;
    logic [PCT_W-1:0]      o_moisture_percent;
    logic [SAMPLE_W-1:0]   o_average_raw;
    logic                  o_report_cause;

    logic no_idle          = 1'b0;
    int   fail_count;
    int   pending;
    int   report_count;
    int   samples_sent     = 0;
    int   settings_applied = 0;
    int   idle_cycles      = 0;
    int   hold_left        = 0;

    moisture_burst_average_reporter_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_sample_valid     (i_sample_valid),
        .o_sample_ready     (o_sample_ready),
        .i_sample           (i_sample),
        .o_report_valid     (o_report_valid),
        .i_report_ready     (i_report_ready),
        .o_moisture_percent (o_moisture_percent),
        .o_average_raw      (o_average_raw),
        .o_report_cause     (o_report_cause),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    mbar_report_checker i_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_sample_valid     (i_sample_valid),
        .i_sample_ready     (o_sample_ready),
        .i_sample           (i_sample),
        .i_report_valid     (o_report_valid),
        .i_report_ready     (i_report_ready),
        .i_moisture_percent (o_moisture_percent),
        .i_average_raw      (o_average_raw),
        .i_report_cause     (o_report_cause),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_report_count     (report_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // report side: fresh hold-off drawn after every transfer
    always @(posedge i_clk) begin : report_sink
        int draw;
        if (!i_rst_n) begin
            i_report_ready <= 1'b0;
            hold_left      <= 0;
        end else if (o_report_valid && i_report_ready) begin
            draw = no_idle ? 0 : $urandom_range(0, 15);
            hold_left      <= draw;
            i_report_ready <= (draw == 0);
        end else if (hold_left > 0) begin
            hold_left      <= hold_left - 1;
            i_report_ready <= (hold_left == 1);
        end else begin
            i_report_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_sample_valid && o_sample_ready)
                || (o_report_valid && i_report_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [SAMPLE_W-1:0] clip10(input int v);
        if (v < 0)
            return '0;
        if (v > 1023)
            return '1;
        return SAMPLE_W'(v);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= value;
        @(posedge i_clk);
        while (!o_sample_ready) @(posedge i_clk);
        samples_sent++;
    endtask

    task automatic settle();
        i_sample_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [SAMPLE_W-1:0] wet,
                                  input logic [SAMPLE_W-1:0] dry,
                                  input logic [QUIET_W-1:0]  max_quiet);
        settle();
        write_reg(CFG_WET_LEVEL, wet);
        write_reg(CFG_DRY_LEVEL, dry);
        write_reg(CFG_MAX_QUIET_BURSTS, {2'($urandom_range(0, 3)), max_quiet});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 1023)));
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    initial begin : stimulus
        int wet;
        int dry;
        int max_quiet;
        int base;
        int mode;
        int bursts;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: driest possible burst (clamps to 0, no change), wettest burst,
        // then a partial burst left open across a register update
        repeat (SAMPLES_PER_BURST) send_sample(10'd1023);
        repeat (SAMPLES_PER_BURST) send_sample(10'd0);
        repeat (5) send_sample(10'd512);
        apply_settings(10'd0, 10'd1023, 8'd0);
        repeat (5) send_sample(10'd512);

        while (samples_sent < TARGET_SAMPLES) begin
            case ($urandom_range(0, 6))
                0: begin wet = 0; dry = 1023; end
                1: begin wet = 1023; dry = 0; end
                2: begin wet = $urandom_range(0, 1023); dry = wet; end
                3: begin wet = $urandom_range(0, 1023); dry = $urandom_range(0, 1023); end
                default: begin
                    wet = $urandom_range(0, 600);
                    dry = wet + $urandom_range(1, 1023 - wet);
                end
            endcase
            case ($urandom_range(0, 4))
                0: max_quiet = 0;
                1: max_quiet = 255;
                2: max_quiet = $urandom_range(1, 3);
                3: max_quiet = $urandom_range(0, 255);
                default: max_quiet = $urandom_range(1, 10);
            endcase
            apply_settings(clip10(wet), clip10(dry), QUIET_W'(max_quiet));
            no_idle <= ($urandom_range(0, 3) == 0);
            base    = $urandom_range(0, 1023);
            bursts  = $urandom_range(4, 12);
            repeat (bursts) begin
                mode = $urandom_range(0, 7);
                repeat (SAMPLES_PER_BURST) begin
                    case (mode)
                        0: send_sample(SAMPLE_W'($urandom_range(0, 1023)));
                        1: send_sample($urandom_range(0, 1) ? 10'd1023 : 10'd0);
                        2: send_sample(clip10(wet + $urandom_range(0, 6) - 3));
                        3: send_sample(clip10(dry + $urandom_range(0, 6) - 3));
                        default: send_sample(clip10(base + $urandom_range(0, 4) - 2));
                    endcase
                end
            end
            // occasionally leave a burst open across the next register update
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, SAMPLES_PER_BURST - 1))
                    send_sample(SAMPLE_W'($urandom_range(0, 1023)));
        end

        settle();
        $display("Run covered %0d samples and %0d reports over %0d register settings.",
                 samples_sent, report_count, settings_applied);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Mismatches: %0d, outstanding reports: %0d", fail_count, pending);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
